@@ rtl/big_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// big_pkg: shared constants for the broadcast index generator
// Default geometry, fixed field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package big_pkg;

	// Default geometry
	localparam int MAX_RANK_DEF   = 4;
	localparam int DIM_WIDTH_DEF  = 16;
	localparam int ADDR_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int IDX_WIDTH       = 32;
	localparam int CFG_DATA_WIDTH  = 64;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int RANKS_WIDTH     = 12;
	localparam int RANK_WIDTH      = 4;
	localparam int OFFSET_WIDTH    = 32;

	// Quotient bits resolved per divider stage
	localparam int DIV_STEP = 4;

	// Configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANKS       = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RES_EXTENTS = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A_EXTENTS   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B_EXTENTS   = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A_STRIDES   = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B_STRIDES   = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OP_OFFSETS  = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RES_OFFSET  = 3'd7;

	// Clamp a rank field to the supported maximum
	function automatic logic [RANK_WIDTH-1:0] sat_rank(input logic [RANK_WIDTH-1:0] r,
		input logic [RANK_WIDTH-1:0] max_r);
		return (r > max_r) ? max_r : r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/big_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// big_axis: one result axis of the index split
// Pipelined restoring division of the running index by the axis extent,
// then the coordinate times both operand strides, then accumulation.
// ----------------------------------------------------------------------------
module big_axis #(
	parameter int DIM_WIDTH  = big_pkg::DIM_WIDTH_DEF,
	parameter int ADDR_WIDTH = big_pkg::ADDR_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [DIM_WIDTH-1:0]           ext,
	input  logic [DIM_WIDTH-1:0]           str_a,
	input  logic [DIM_WIDTH-1:0]           str_b,
	input  logic                           in_valid,
	input  logic [big_pkg::IDX_WIDTH-1:0]  in_rem,
	input  logic [big_pkg::IDX_WIDTH-1:0]  in_idx,
	input  logic [ADDR_WIDTH-1:0]          in_acc_a,
	input  logic [ADDR_WIDTH-1:0]          in_acc_b,
	output logic                           out_valid,
	output logic [big_pkg::IDX_WIDTH-1:0]  out_rem,
	output logic [big_pkg::IDX_WIDTH-1:0]  out_idx,
	output logic [ADDR_WIDTH-1:0]          out_acc_a,
	output logic [ADDR_WIDTH-1:0]          out_acc_b
);
	import big_pkg::*;

	localparam int NSTG = IDX_WIDTH / DIV_STEP;

	logic                  div_v_s     [NSTG+1];
	logic [DIM_WIDTH-1:0]  div_r_s     [NSTG+1];
	logic [IDX_WIDTH-1:0]  div_n_s     [NSTG+1];
	logic [IDX_WIDTH-1:0]  div_idx_s   [NSTG+1];
	logic [ADDR_WIDTH-1:0] div_acc_a_s [NSTG+1];
	logic [ADDR_WIDTH-1:0] div_acc_b_s [NSTG+1];

	// Enter the divider with an empty partial remainder
	assign div_v_s[0]     = in_valid;
	assign div_r_s[0]     = '0;
	assign div_n_s[0]     = in_rem;
	assign div_idx_s[0]   = in_idx;
	assign div_acc_a_s[0] = in_acc_a;
	assign div_acc_b_s[0] = in_acc_b;

	genvar g;
	generate
		for (g = 0; g < NSTG; g++) begin : g_div
			logic [DIM_WIDTH-1:0] r_c;
			logic [IDX_WIDTH-1:0] n_c;

			// Resolve DIV_STEP quotient bits, shifting them into the dividend word
			always_comb begin
				logic [DIM_WIDTH:0] t;
				r_c = div_r_s[g];
				n_c = div_n_s[g];
				t   = '0;
				for (int k = 0; k < DIV_STEP; k++) begin
					t   = {r_c, n_c[IDX_WIDTH-1]};
					n_c = {n_c[IDX_WIDTH-2:0], 1'b0};
					if (t >= {1'b0, ext}) begin
						t      = t - {1'b0, ext};
						n_c[0] = 1'b1;
					end
					r_c = t[DIM_WIDTH-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_v_s[g+1] <= 1'b0;
				end else if (en) begin
					div_v_s[g+1] <= div_v_s[g];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					div_r_s[g+1]     <= r_c;
					div_n_s[g+1]     <= n_c;
					div_idx_s[g+1]   <= div_idx_s[g];
					div_acc_a_s[g+1] <= div_acc_a_s[g];
					div_acc_b_s[g+1] <= div_acc_b_s[g];
				end
			end
		end
	endgenerate

	// Multiply stage: remainder is the coordinate
	logic                     mul_v_s1;
	logic [2*DIM_WIDTH-1:0]   mul_pa_s1;
	logic [2*DIM_WIDTH-1:0]   mul_pb_s1;
	logic [IDX_WIDTH-1:0]     mul_rem_s1;
	logic [IDX_WIDTH-1:0]     mul_idx_s1;
	logic [ADDR_WIDTH-1:0]    mul_acc_a_s1;
	logic [ADDR_WIDTH-1:0]    mul_acc_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1 <= 1'b0;
		end else if (en) begin
			mul_v_s1 <= div_v_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_pa_s1    <= div_r_s[NSTG] * str_a;
			mul_pb_s1    <= div_r_s[NSTG] * str_b;
			mul_rem_s1   <= div_n_s[NSTG];
			mul_idx_s1   <= div_idx_s[NSTG];
			mul_acc_a_s1 <= div_acc_a_s[NSTG];
			mul_acc_b_s1 <= div_acc_b_s[NSTG];
		end
	end

	// Accumulate stage, modulo the address width
	logic                  add_v_s2;
	logic [IDX_WIDTH-1:0]  add_rem_s2;
	logic [IDX_WIDTH-1:0]  add_idx_s2;
	logic [ADDR_WIDTH-1:0] add_acc_a_s2;
	logic [ADDR_WIDTH-1:0] add_acc_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_v_s2 <= 1'b0;
		end else if (en) begin
			add_v_s2 <= mul_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			add_rem_s2   <= mul_rem_s1;
			add_idx_s2   <= mul_idx_s1;
			add_acc_a_s2 <= mul_acc_a_s1 + ADDR_WIDTH'(mul_pa_s1);
			add_acc_b_s2 <= mul_acc_b_s1 + ADDR_WIDTH'(mul_pb_s1);
		end
	end

	assign out_valid = add_v_s2;
	assign out_rem   = add_rem_s2;
	assign out_idx   = add_idx_s2;
	assign out_acc_a = add_acc_a_s2;
	assign out_acc_b = add_acc_b_s2;

endmodule
`default_nettype wire

@@ rtl/broadcast_index_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle while the output is not stalled; each axis
// divider resolves 4 quotient bits a stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all configuration registers and every pipeline valid bit.
// ----------------------------------------------------------------------------
// broadcast_index_generator: tensor broadcast address generator
// Splits a flat result index into per-axis coordinates and forms the A, B
// and result element addresses with broadcast strides and base offsets.
// ----------------------------------------------------------------------------
module broadcast_index_generator #(
	parameter int MAX_RANK   = big_pkg::MAX_RANK_DEF,
	parameter int DIM_WIDTH  = big_pkg::DIM_WIDTH_DEF,
	parameter int ADDR_WIDTH = big_pkg::ADDR_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [big_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [big_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [big_pkg::IDX_WIDTH-1:0]       flat_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ADDR_WIDTH-1:0]               addr_a,
	output logic [ADDR_WIDTH-1:0]               addr_b,
	output logic [ADDR_WIDTH-1:0]               addr_out
);
	import big_pkg::*;

	localparam logic [RANK_WIDTH-1:0] MAX_R = RANK_WIDTH'(MAX_RANK);

	// Configuration registers
	logic [RANKS_WIDTH-1:0]    ranks_q;
	logic [CFG_DATA_WIDTH-1:0] res_ext_q;
	logic [CFG_DATA_WIDTH-1:0] a_ext_q;
	logic [CFG_DATA_WIDTH-1:0] b_ext_q;
	logic [CFG_DATA_WIDTH-1:0] a_str_q;
	logic [CFG_DATA_WIDTH-1:0] b_str_q;
	logic [CFG_DATA_WIDTH-1:0] op_off_q;
	logic [OFFSET_WIDTH-1:0]   res_off_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranks_q   <= '0;
			res_ext_q <= '0;
			a_ext_q   <= '0;
			b_ext_q   <= '0;
			a_str_q   <= '0;
			b_str_q   <= '0;
			op_off_q  <= '0;
			res_off_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RANKS:       ranks_q   <= cfg_data[RANKS_WIDTH-1:0];
				REG_RES_EXTENTS: res_ext_q <= cfg_data;
				REG_A_EXTENTS:   a_ext_q   <= cfg_data;
				REG_B_EXTENTS:   b_ext_q   <= cfg_data;
				REG_A_STRIDES:   a_str_q   <= cfg_data;
				REG_B_STRIDES:   b_str_q   <= cfg_data;
				REG_OP_OFFSETS:  op_off_q  <= cfg_data;
				REG_RES_OFFSET:  res_off_q <= cfg_data[OFFSET_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Saturated ranks
	logic [RANK_WIDTH-1:0] rr, ra, rb;
	assign rr = sat_rank(ranks_q[3:0], MAX_R);
	assign ra = sat_rank(ranks_q[7:4], MAX_R);
	assign rb = sat_rank(ranks_q[11:8], MAX_R);

	// Pipeline advances unless a finished request is stuck at the output
	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Axis chain, outermost slot handles the innermost axis
	logic                  ch_v     [MAX_RANK+1];
	logic [IDX_WIDTH-1:0]  ch_rem   [MAX_RANK+1];
	logic [IDX_WIDTH-1:0]  ch_idx   [MAX_RANK+1];
	logic [ADDR_WIDTH-1:0] ch_acc_a [MAX_RANK+1];
	logic [ADDR_WIDTH-1:0] ch_acc_b [MAX_RANK+1];

	assign ch_v[0]     = in_valid && en;
	assign ch_rem[0]   = flat_index;
	assign ch_idx[0]   = flat_index;
	assign ch_acc_a[0] = ADDR_WIDTH'(op_off_q[31:0]);
	assign ch_acc_b[0] = ADDR_WIDTH'(op_off_q[63:32]);

	genvar j;
	generate
		for (j = 0; j < MAX_RANK; j++) begin : g_axis
			localparam logic [RANK_WIDTH-1:0] D = RANK_WIDTH'(MAX_RANK - 1 - j);
			localparam int DI = MAX_RANK - 1 - j;

			logic [DIM_WIDTH-1:0] ext_eff;
			logic [DIM_WIDTH-1:0] sa, sb;

			// Result extent: inactive axes and zero extents divide as one
			always_comb begin
				logic [DIM_WIDTH-1:0] e;
				e = res_ext_q[DIM_WIDTH*DI +: DIM_WIDTH];
				if (D >= rr || e == '0) begin
					ext_eff = DIM_WIDTH'(1);
				end else begin
					ext_eff = e;
				end
			end

			// Broadcast stride of A at this axis
			always_comb begin
				logic [RANK_WIDTH:0]   s;
				logic [RANK_WIDTH:0]   k;
				logic [DIM_WIDTH-1:0]  e;
				s  = {1'b0, D} + {1'b0, ra};
				k  = s - {1'b0, rr};
				e  = a_ext_q[DIM_WIDTH*k[1:0] +: DIM_WIDTH];
				if (s < {1'b0, rr} || e <= DIM_WIDTH'(1)) begin
					sa = '0;
				end else begin
					sa = a_str_q[DIM_WIDTH*k[1:0] +: DIM_WIDTH];
				end
			end

			// Broadcast stride of B at this axis
			always_comb begin
				logic [RANK_WIDTH:0]   s;
				logic [RANK_WIDTH:0]   k;
				logic [DIM_WIDTH-1:0]  e;
				s  = {1'b0, D} + {1'b0, rb};
				k  = s - {1'b0, rr};
				e  = b_ext_q[DIM_WIDTH*k[1:0] +: DIM_WIDTH];
				if (s < {1'b0, rr} || e <= DIM_WIDTH'(1)) begin
					sb = '0;
				end else begin
					sb = b_str_q[DIM_WIDTH*k[1:0] +: DIM_WIDTH];
				end
			end

			big_axis #(
				.DIM_WIDTH (DIM_WIDTH),
				.ADDR_WIDTH(ADDR_WIDTH)
			) u_axis (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.ext      (ext_eff),
				.str_a    (sa),
				.str_b    (sb),
				.in_valid (ch_v[j]),
				.in_rem   (ch_rem[j]),
				.in_idx   (ch_idx[j]),
				.in_acc_a (ch_acc_a[j]),
				.in_acc_b (ch_acc_b[j]),
				.out_valid(ch_v[j+1]),
				.out_rem  (ch_rem[j+1]),
				.out_idx  (ch_idx[j+1]),
				.out_acc_a(ch_acc_a[j+1]),
				.out_acc_b(ch_acc_b[j+1])
			);
		end
	endgenerate

	// Output register; leftover quotient bits are dropped
	logic [ADDR_WIDTH-1:0] addr_a_q, addr_b_q, addr_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ch_v[MAX_RANK];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_a_q   <= ch_acc_a[MAX_RANK];
			addr_b_q   <= ch_acc_b[MAX_RANK];
			addr_out_q <= ADDR_WIDTH'(res_off_q + ch_idx[MAX_RANK]);
		end
	end

	assign out_valid = out_valid_q;
	assign addr_a    = addr_a_q;
	assign addr_b    = addr_b_q;
	assign addr_out  = addr_out_q;

endmodule
`default_nettype wire

@@ verif/broadcast_index_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_index_generator_tb: regression for the broadcast address generator
// Programs ranks, extents, strides and offsets, streams flat indexes with
// bursty requests and a stalling receiver, and checks every address triple
// against a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module broadcast_index_generator_tb;
	import big_pkg::*;

	localparam int LATENCY = 41;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] o;
	} addr_triple_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IDX_WIDTH-1:0] flat_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] addr_a, addr_b, addr_out;

	// shadow copy of the register file
	logic [11:0] sh_ranks;
	logic [63:0] sh_res_ext, sh_a_ext, sh_b_ext, sh_a_str, sh_b_str, sh_offs;
	logic [31:0] sh_res_off;

	addr_triple_t pending_addrs[$];
	int errors = 0;
	int cycles = 0;
	int stall_pct = 30;

	broadcast_index_generator dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("broadcast_index_generator regression: fail");
			$finish;
		end
	end

	function automatic int clamp_rank(input logic [3:0] r);
		return (r > 4) ? 4 : int'(r);
	endfunction

	function automatic logic [15:0] fld(input logic [63:0] w, input int ax);
		return w[16*ax +: 16];
	endfunction

	// stride of an operand seen from result axis d after broadcasting
	function automatic logic [31:0] bstride(input int d, input int rr, input int orank,
		input logic [63:0] ext, input logic [63:0] str);
		int k;
		if (d + orank < rr) return 32'd0;
		k = d + orank - rr;
		if (fld(ext, k) <= 16'd1) return 32'd0;
		return {16'd0, fld(str, k)};
	endfunction

	function automatic addr_triple_t predict_addrs(input logic [31:0] idx);
		addr_triple_t t;
		logic [31:0] rem, e, c;
		int rr, ra, rb;
		rr = clamp_rank(sh_ranks[3:0]);
		ra = clamp_rank(sh_ranks[7:4]);
		rb = clamp_rank(sh_ranks[11:8]);
		rem = idx;
		t.a = sh_offs[31:0];
		t.b = sh_offs[63:32];
		for (int d = rr - 1; d >= 0; d--) begin
			e = {16'd0, fld(sh_res_ext, d)};
			if (e == 0) e = 1;
			c = rem % e;
			rem = rem / e;
			t.a = t.a + c * bstride(d, rr, ra, sh_a_ext, sh_a_str);
			t.b = t.b + c * bstride(d, rr, rb, sh_b_ext, sh_b_str);
		end
		t.o = sh_res_off + idx;
		return t;
	endfunction

	// receiver: stall at random, compare against the oldest expectation
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		addr_triple_t exp_t;
		if (out_valid && out_ready) begin
			if (pending_addrs.size() == 0) begin
				$display("%0t: unexpected result a=%h b=%h o=%h", $time, addr_a, addr_b,
					addr_out);
				errors++;
			end else begin
				exp_t = pending_addrs.pop_front();
				if (addr_a !== exp_t.a) begin
					$display("%0t: addr_a exp %h got %h", $time, exp_t.a, addr_a);
					errors++;
				end
				if (addr_b !== exp_t.b) begin
					$display("%0t: addr_b exp %h got %h", $time, exp_t.b, addr_b);
					errors++;
				end
				if (addr_out !== exp_t.o) begin
					$display("%0t: addr_out exp %h got %h", $time, exp_t.o, addr_out);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] ix, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (ix)
			REG_RANKS:       sh_ranks = val[11:0];
			REG_RES_EXTENTS: sh_res_ext = val;
			REG_A_EXTENTS:   sh_a_ext = val;
			REG_B_EXTENTS:   sh_b_ext = val;
			REG_A_STRIDES:   sh_a_str = val;
			REG_B_STRIDES:   sh_b_str = val;
			REG_OP_OFFSETS:  sh_offs = val;
			default:         sh_res_off = val[31:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait out every expected result before touching the registers
	task automatic drain;
		while (pending_addrs.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// send one request; valid stays high across back-to-back requests
	task automatic send_index(input logic [31:0] idx);
		in_valid <= 1'b1;
		flat_index <= idx;
		do @(posedge clk); while (!in_ready);
		pending_addrs.push_back(predict_addrs(idx));
		@(negedge clk);
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic program_all(input logic [11:0] rk, input logic [63:0] re,
		input logic [63:0] ae, input logic [63:0] be, input logic [63:0] as,
		input logic [63:0] bs, input logic [63:0] of, input logic [31:0] ro);
		drain();
		write_reg(REG_RANKS, {52'd0, rk});
		write_reg(REG_RES_EXTENTS, re);
		write_reg(REG_A_EXTENTS, ae);
		write_reg(REG_B_EXTENTS, be);
		write_reg(REG_A_STRIDES, as);
		write_reg(REG_B_STRIDES, bs);
		write_reg(REG_OP_OFFSETS, of);
		write_reg(REG_RES_OFFSET, {32'd0, ro});
	endtask

	function automatic logic [63:0] rand64;
		return {$urandom, $urandom};
	endfunction

	// small extents keep the index space reachable
	function automatic logic [63:0] rand_ext;
		logic [63:0] v;
		for (int i = 0; i < 4; i++)
			v[16*i +: 16] = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
		return v;
	endfunction

	task automatic test_reset_defaults;
		send_index(32'd0);
		send_index(32'hFFFF_FFFF);
		send_index(32'h1234_5678);
		idle_sender(1);
	endtask

	task automatic test_directed_shapes;
		// plain 2x3x4 against full-rank operands
		program_all(12'h333, 64'h0000_0004_0003_0002, 64'h0000_0004_0003_0002,
			64'h0000_0004_0001_0002, 64'h0000_0001_0004_000C,
			64'h0000_0001_0000_0004, 64'h0000_0100_0000_0010, 32'd5);
		for (int i = 0; i < 25; i++) send_index(i);
		idle_sender(1);
		// left-padded operands, zero extents, rank saturation
		program_all(12'h2F4, 64'h0005_0000_0003_0002, 64'h0000_0000_0005_0003,
			64'hFFFF_0000_0005_0001, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0007_0003_0002_0001, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF);
		send_index(32'd0);
		send_index(32'd29);
		send_index(32'd30);
		send_index(32'hFFFF_FFFF);
		send_index(32'h8000_0000);
		idle_sender(1);
		// result rank zero, operand rank above result rank
		program_all(12'h440, rand_ext(), rand_ext(), rand_ext(), rand64(), rand64(),
			rand64(), $urandom);
		send_index(32'd7);
		send_index(32'hFFFF_FFFF);
		idle_sender(1);
		program_all(12'h431, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_index(32'hFFFF_FFFF);
		send_index(32'h0001_FFFF);
		idle_sender(1);
	endtask

	task automatic test_random_bursts;
		logic [31:0] span, idx;
		int burst;
		for (int phase = 0; phase < 13; phase++) begin
			program_all(12'($urandom), rand_ext(), rand_ext(), rand_ext(), rand64(),
				rand64(), rand64(), $urandom);
			stall_pct = (phase % 4 == 0) ? 0 : $urandom_range(70);
			span = 1;
			for (int i = 0; i < 4; i++) span = span * (fld(sh_res_ext, i) == 0 ? 1 :
				fld(sh_res_ext, i));
			for (int n = 0; n < 150; ) begin
				burst = $urandom_range(1, 20);
				for (int j = 0; j < burst; j++) begin
					case ($urandom_range(9))
						0: idx = $urandom;
						1: idx = 32'hFFFF_FFFF - $urandom_range(3);
						default: idx = $urandom_range(span - 1);
					endcase
					send_index(idx);
					n++;
				end
				if (phase == 6) begin
					// hold the sender until the pipe is empty
					in_valid <= 1'b0;
					while (pending_addrs.size() != 0) @(negedge clk);
				end else if (phase % 4 != 0) idle_sender($urandom_range(0, 6));
			end
			idle_sender(1);
		end
		stall_pct = 30;
	endtask

	initial begin
		{sh_ranks, sh_res_ext, sh_a_ext, sh_b_ext, sh_a_str, sh_b_str, sh_offs,
			sh_res_off} = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed_shapes();
		test_random_bursts();
		drain();
		if (errors == 0) begin
			$display("broadcast_index_generator regression: pass");
		end else begin
			$display("broadcast_index_generator regression: fail");
		end
		$finish;
	end

endmodule

@@ broadcast_index_generator.f @@
rtl/big_pkg.sv
rtl/big_axis.sv
rtl/broadcast_index_generator.sv
verif/broadcast_index_generator_tb.sv
